### hw/rtl/babd_pkg.sv
`timescale 1ns / 1ps

package babd_pkg;

    localparam logic [8:0]  RANGE_START = 9'h1FE;
    localparam logic [8:0]  RANGE_MIN   = 9'h100;
    localparam logic [8:0]  TERM_DEC    = 9'd2;
    localparam logic [4:0]  PEND_START  = 5'd15;
    localparam logic [5:0]  WORD_BITS   = 6'd16;
    localparam logic [5:0]  QP_MAX      = 6'd51;
    localparam logic [5:0]  QP_RESET    = 6'd26;
    localparam logic [5:0]  ST_MPS_TOP  = 6'd62;
    localparam logic signed [10:0] PRE_LO = 11'sd1;
    localparam logic signed [10:0] PRE_HI = 11'sd126;
    localparam int CTX_W = 7;

    typedef enum logic [2:0] {
        REQ_START     = 3'd0,
        REQ_INIT      = 3'd1,
        REQ_REGULAR   = 3'd2,
        REQ_BYPASS    = 3'd3,
        REQ_TERMINATE = 3'd4
    } t_req_type;

    typedef struct packed {
        logic [24:0] offset;
        logic [8:0]  range;
        logic [4:0]  pend;
    } t_arith_state;

    typedef struct packed {
        logic [2:0]         kind;
        logic               idx_ok;
        logic signed [7:0]  init_m;
        logic signed [7:0]  init_n;
        logic [23:0]        stream;
    } t_req;

    typedef struct packed {
        logic             we;
        logic [CTX_W-1:0] data;
    } t_ctx_wr;

    typedef struct packed {
        logic bin;
        logic used;
    } t_result;

    // lps range indexed by probability state and range quarter
    localparam logic [7:0] LPS_TAB [64][4] = '{
        '{8'd128, 8'd176, 8'd208, 8'd240}, '{8'd128, 8'd167, 8'd197, 8'd227},
        '{8'd128, 8'd158, 8'd187, 8'd216}, '{8'd123, 8'd150, 8'd178, 8'd205},
        '{8'd116, 8'd142, 8'd169, 8'd195}, '{8'd111, 8'd135, 8'd160, 8'd185},
        '{8'd105, 8'd128, 8'd152, 8'd175}, '{8'd100, 8'd122, 8'd144, 8'd166},
        '{8'd95,  8'd116, 8'd137, 8'd158}, '{8'd90,  8'd110, 8'd130, 8'd150},
        '{8'd85,  8'd104, 8'd123, 8'd142}, '{8'd81,  8'd99,  8'd117, 8'd135},
        '{8'd77,  8'd94,  8'd111, 8'd128}, '{8'd73,  8'd89,  8'd105, 8'd122},
        '{8'd69,  8'd85,  8'd100, 8'd116}, '{8'd66,  8'd80,  8'd95,  8'd110},
        '{8'd62,  8'd76,  8'd90,  8'd104}, '{8'd59,  8'd72,  8'd86,  8'd99},
        '{8'd56,  8'd69,  8'd81,  8'd94},  '{8'd53,  8'd65,  8'd77,  8'd89},
        '{8'd51,  8'd62,  8'd73,  8'd85},  '{8'd48,  8'd59,  8'd69,  8'd80},
        '{8'd46,  8'd56,  8'd66,  8'd76},  '{8'd43,  8'd53,  8'd63,  8'd72},
        '{8'd41,  8'd50,  8'd59,  8'd69},  '{8'd39,  8'd48,  8'd56,  8'd65},
        '{8'd37,  8'd45,  8'd54,  8'd62},  '{8'd35,  8'd43,  8'd51,  8'd59},
        '{8'd33,  8'd41,  8'd48,  8'd56},  '{8'd32,  8'd39,  8'd46,  8'd53},
        '{8'd30,  8'd37,  8'd43,  8'd50},  '{8'd29,  8'd35,  8'd41,  8'd48},
        '{8'd27,  8'd33,  8'd39,  8'd45},  '{8'd26,  8'd31,  8'd37,  8'd43},
        '{8'd24,  8'd30,  8'd35,  8'd41},  '{8'd23,  8'd28,  8'd33,  8'd39},
        '{8'd22,  8'd27,  8'd32,  8'd37},  '{8'd21,  8'd26,  8'd30,  8'd35},
        '{8'd20,  8'd24,  8'd29,  8'd33},  '{8'd19,  8'd23,  8'd27,  8'd31},
        '{8'd18,  8'd22,  8'd26,  8'd30},  '{8'd17,  8'd21,  8'd25,  8'd28},
        '{8'd16,  8'd20,  8'd23,  8'd27},  '{8'd15,  8'd19,  8'd22,  8'd25},
        '{8'd14,  8'd18,  8'd21,  8'd24},  '{8'd14,  8'd17,  8'd20,  8'd23},
        '{8'd13,  8'd16,  8'd19,  8'd22},  '{8'd12,  8'd15,  8'd18,  8'd21},
        '{8'd12,  8'd14,  8'd17,  8'd20},  '{8'd11,  8'd14,  8'd16,  8'd19},
        '{8'd11,  8'd13,  8'd15,  8'd18},  '{8'd10,  8'd12,  8'd15,  8'd17},
        '{8'd10,  8'd12,  8'd14,  8'd16},  '{8'd9,   8'd11,  8'd13,  8'd15},
        '{8'd9,   8'd11,  8'd12,  8'd14},  '{8'd8,   8'd10,  8'd12,  8'd14},
        '{8'd8,   8'd9,   8'd11,  8'd13},  '{8'd7,   8'd9,   8'd11,  8'd12},
        '{8'd7,   8'd9,   8'd10,  8'd12},  '{8'd7,   8'd8,   8'd10,  8'd11},
        '{8'd6,   8'd8,   8'd9,   8'd11},  '{8'd6,   8'd7,   8'd9,   8'd10},
        '{8'd6,   8'd7,   8'd8,   8'd9},   '{8'd2,   8'd2,   8'd2,   8'd2}
    };

    localparam logic [5:0] AFTER_LPS [64] = '{
        6'd0,  6'd0,  6'd1,  6'd2,  6'd2,  6'd4,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd9,  6'd11, 6'd11, 6'd12,
        6'd13, 6'd13, 6'd15, 6'd15, 6'd16, 6'd16, 6'd18, 6'd18,
        6'd19, 6'd19, 6'd21, 6'd21, 6'd22, 6'd22, 6'd23, 6'd24,
        6'd24, 6'd25, 6'd26, 6'd26, 6'd27, 6'd27, 6'd28, 6'd29,
        6'd29, 6'd30, 6'd30, 6'd30, 6'd31, 6'd32, 6'd32, 6'd33,
        6'd33, 6'd33, 6'd34, 6'd34, 6'd35, 6'd35, 6'd35, 6'd36,
        6'd36, 6'd36, 6'd37, 6'd37, 6'd37, 6'd38, 6'd38, 6'd63
    };

    function automatic logic [5:0] after_mps(input logic [5:0] st);
        return (st >= ST_MPS_TOP) ? st : st + 6'd1;
    endfunction

    // renormalization shift after an lps, from rlps[7:3]
    function automatic logic [2:0] lps_shift(input logic [4:0] q);
        logic [2:0] sh;
        priority if (q[4]) sh = 3'd1;
        else if (q[3])     sh = 3'd2;
        else if (q[2])     sh = 3'd3;
        else if (q[1])     sh = 3'd4;
        else if (q[0])     sh = 3'd5;
        else               sh = 3'd6;
        return sh;
    endfunction

    function automatic logic [24:0] scale_range(input logic [8:0] rng, input logic [4:0] sh);
        return 25'(rng) << sh;
    endfunction

endpackage

### hw/rtl/babd_ram.sv
`timescale 1ns / 1ps

module babd_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/babd_core.sv
`timescale 1ns / 1ps

module babd_core
    import babd_pkg::*;
(
    input  t_arith_state     i_state,
    input  t_req             i_req,
    input  logic [CTX_W-1:0] i_ctx,
    input  logic [5:0]       i_qp,
    output t_arith_state     o_state,
    output t_ctx_wr          o_ctx_wr,
    output t_result          o_result
);

    logic [5:0]  st;
    logic        mps;
    logic [7:0]  rlps;
    logic [8:0]  rmps;
    logic [24:0] reg_scaled;
    logic        reg_mps_path;
    logic [2:0]  sh;
    logic [13:0] rlps_sh;
    logic [8:0]  trm_r;
    logic [24:0] trm_scaled;
    logic        trm_stay;

    logic [5:0]         qp_sat;
    logic signed [14:0] m_ext;
    logic signed [14:0] qp_ext;
    logic signed [14:0] prod;
    logic signed [10:0] pre;
    logic [6:0]         pre_clamp;
    logic [CTX_W-1:0]   init_ctx;

    logic [24:0] nxt_off;
    logic [8:0]  nxt_range;
    logic [5:0]  nxt_pend;
    logic        refill_ok;
    logic        byp;
    logic        bin;
    logic        used;
    logic [24:0] byp_scaled;
    t_ctx_wr     ctx_wr;

    // regular bin datapath
    assign st           = i_ctx[5:0];
    assign mps          = i_ctx[6];
    assign rlps         = LPS_TAB[st][i_state.range[7:6]];
    assign rmps         = i_state.range - {1'b0, rlps};
    assign reg_scaled   = scale_range(rmps, i_state.pend);
    assign reg_mps_path = i_state.offset < reg_scaled;
    assign sh           = lps_shift(rlps[7:3]);
    assign rlps_sh      = 14'(rlps) << sh;

    // terminate datapath
    assign trm_r      = i_state.range - TERM_DEC;
    assign trm_scaled = scale_range(trm_r, i_state.pend);
    assign trm_stay   = i_state.offset < trm_scaled;

    // context init: floor((m * qp) / 16) + n, clamped to 1..126
    assign qp_sat = (i_qp > QP_MAX) ? QP_MAX : i_qp;
    assign m_ext  = 15'(i_req.init_m);
    assign qp_ext = signed'({9'b0, qp_sat});
    assign prod   = m_ext * qp_ext;
    assign pre    = 11'(prod >>> 4) + 11'(i_req.init_n);

    always_comb begin
        if (pre < PRE_LO) begin
            pre_clamp = PRE_LO[6:0];
        end else if (pre > PRE_HI) begin
            pre_clamp = PRE_HI[6:0];
        end else begin
            pre_clamp = pre[6:0];
        end
    end

    // upper half maps to mps 1, lower half mirrors to mps 0
    assign init_ctx = pre_clamp[6] ? {1'b1, pre_clamp[5:0]} : {1'b0, ~pre_clamp[5:0]};

    always_comb begin
        nxt_off    = i_state.offset;
        nxt_range  = i_state.range;
        nxt_pend   = {1'b0, i_state.pend};
        refill_ok  = 1'b0;
        byp        = 1'b0;
        bin        = 1'b0;
        used       = 1'b0;
        ctx_wr     = '0;
        byp_scaled = '0;

        unique case (t_req_type'(i_req.kind))
            REQ_START: begin
                nxt_off   = 25'(i_req.stream);
                nxt_range = RANGE_START;
                nxt_pend  = {1'b0, PEND_START};
            end
            REQ_INIT: begin
                ctx_wr.we   = i_req.idx_ok;
                ctx_wr.data = init_ctx;
            end
            REQ_REGULAR: begin
                refill_ok = 1'b1;
                ctx_wr.we = i_req.idx_ok;
                if (reg_mps_path) begin
                    bin = mps;
                    ctx_wr.data = {mps, after_mps(st)};
                    if (rmps < RANGE_MIN) begin
                        nxt_range = {rmps[7:0], 1'b0};
                        nxt_pend  = nxt_pend - 6'd1;
                    end else begin
                        nxt_range = rmps;
                    end
                end else begin
                    bin = ~mps;
                    ctx_wr.data = {mps ^ (st == 6'd0), AFTER_LPS[st]};
                    nxt_off   = i_state.offset - reg_scaled;
                    nxt_range = rlps_sh[8:0];
                    nxt_pend  = nxt_pend - {3'b0, sh};
                end
            end
            REQ_BYPASS: begin
                refill_ok = 1'b1;
                byp       = 1'b1;
                nxt_pend  = nxt_pend - 6'd1;
            end
            REQ_TERMINATE: begin
                if (trm_stay) begin
                    if (trm_r >= RANGE_MIN) begin
                        nxt_range = trm_r;
                    end else begin
                        nxt_range = {trm_r[7:0], 1'b0};
                        nxt_pend  = nxt_pend - 6'd1;
                        refill_ok = 1'b1;
                    end
                end else begin
                    bin = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // count ran out: shift in the next stream word
        if (refill_ok && (nxt_pend[5] || nxt_pend == 6'd0)) begin
            nxt_off  = {nxt_off[8:0], i_req.stream[15:0]};
            nxt_pend = nxt_pend + WORD_BITS;
            used     = 1'b1;
        end

        // bypass compares after the refill
        if (byp) begin
            byp_scaled = scale_range(nxt_range, nxt_pend[4:0]);
            if (nxt_off >= byp_scaled) begin
                nxt_off = nxt_off - byp_scaled;
                bin     = 1'b1;
            end
        end
    end

    assign o_state.offset = nxt_off;
    assign o_state.range  = nxt_range;
    assign o_state.pend   = nxt_pend[4:0];
    assign o_ctx_wr       = ctx_wr;
    assign o_result.bin   = bin;
    assign o_result.used  = used;

endmodule

### hw/rtl/binary_arithmetic_bin_decoder.sv
`timescale 1ns / 1ps

// Arithmetic decoding engine with a context store of NUM_CONTEXTS entries. One request
// is taken per clock while the output is not stalled: a request enters the input
// register while its context entry is read from the context memory, and once the
// result register is free the engine decodes it, writes the context back and loads
// the result register. The rate of one request per cycle without output stalls
// rests on the combinational range/offset update and the single read and write
// port of the context memory; a write and a read of the same entry in the same
// cycle are forwarded. Contexts are undefined until initialized, so there is no
// clearing pass after reset. Byte addressing of the stream buffer is the host's.
module binary_arithmetic_bin_decoder
    import babd_pkg::*;
#(
    parameter int NUM_CONTEXTS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_req_type,
    input  logic [9:0]        i_ctx_index,
    input  logic signed [7:0] i_init_m,
    input  logic signed [7:0] i_init_n,
    input  logic [23:0]       i_stream_bits,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_bin,
    output logic              o_word_consumed,
    output logic [4:0]        o_bits_left,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [5:0]        i_cfg_data
);

    localparam int AW = $clog2(NUM_CONTEXTS);
    localparam logic [31:0] CTX_LIMIT = 32'(NUM_CONTEXTS);

    logic             r_s1_valid;
    t_req             r_s1_req;
    logic [AW-1:0]    r_s1_addr;
    logic             r_fwd_hit;
    logic [CTX_W-1:0] r_fwd_data;
    t_arith_state     r_state;
    logic [5:0]       r_qp;
    logic             r_out_valid;
    t_result          r_result;
    logic [4:0]       r_bits_left;

    logic             in_accept;
    logic             out_ready;
    logic             s1_fire;
    logic [AW-1:0]    rd_addr;
    logic             ram_we;
    logic [CTX_W-1:0] ctx_rdata;
    logic [CTX_W-1:0] ctx_eff;
    t_arith_state     core_state;
    t_ctx_wr          core_ctx_wr;
    t_result          core_result;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_ready;
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign rd_addr    = AW'(i_ctx_index);
    assign ram_we     = s1_fire && core_ctx_wr.we;
    assign o_cfg_ready = 1'b1;

    babd_ram #(
        .WIDTH (CTX_W),
        .DEPTH (NUM_CONTEXTS)
    ) u_ctx_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (core_ctx_wr.data),
        .i_re    (in_accept),
        .i_raddr (rd_addr),
        .o_rdata (ctx_rdata)
    );

    // out-of-range index decodes with state 0, mps 0
    assign ctx_eff = !r_s1_req.idx_ok ? '0 : (r_fwd_hit ? r_fwd_data : ctx_rdata);

    babd_core u_core (
        .i_state  (r_state),
        .i_req    (r_s1_req),
        .i_ctx    (ctx_eff),
        .i_qp     (r_qp),
        .o_state  (core_state),
        .o_ctx_wr (core_ctx_wr),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_state.offset <= '0;
            r_state.range  <= RANGE_START;
            r_state.pend   <= PEND_START;
            r_qp           <= QP_RESET;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_fire) begin
                r_state <= core_state;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_qp <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_req.kind   <= i_req_type;
            r_s1_req.idx_ok <= 32'(i_ctx_index) < CTX_LIMIT;
            r_s1_req.init_m <= i_init_m;
            r_s1_req.init_n <= i_init_n;
            r_s1_req.stream <= i_stream_bits;
            r_s1_addr       <= rd_addr;
            // write-back landing on the same edge as this read
            r_fwd_hit       <= ram_we && (r_s1_addr == rd_addr);
            r_fwd_data      <= core_ctx_wr.data;
        end
        if (s1_fire) begin
            r_result    <= core_result;
            r_bits_left <= core_state.pend;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_bin           = r_result.bin;
    assign o_word_consumed = r_result.used;
    assign o_bits_left     = r_bits_left;

`ifndef SYNTHESIS
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.pend != 5'd0) && (r_state.pend <= 5'd16))
        else $error("bit count out of range");

    a_refill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_word_consumed) |-> (o_bits_left >= 5'd11))
        else $error("word consumed with too small a bit count");

    a_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_req.kind == REQ_START) |=>
        (r_state.range == RANGE_START && r_state.pend == PEND_START))
        else $error("start transaction did not reset the interval");

    a_no_fire_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !ram_we && !s1_fire)
        else $error("engine advanced while the result register was held");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import babd_pkg::*;

    localparam int          CTX_DEPTH      = 1024;
    localparam int          PHASE_REQS     = 125;
    localparam int          NUM_PHASES     = 6;
    localparam int          MAX_WAIT       = 13;
    localparam int          DRAIN_CYCLES   = 10;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam logic [2:0]  REQ_UNUSED_LO  = 3'd5;
    localparam logic [2:0]  REQ_UNUSED_HI  = 3'd7;
    localparam logic [8:0]  FULL_RANGE     = 9'h1FE;
    localparam logic [8:0]  HALF_RANGE     = 9'h100;
    localparam int          START_PEND     = 15;
    localparam int          QP_CLAMP       = 51;

    // slice qp per written phase, the last phase draws its own
    localparam logic [5:0] QP_SETTINGS [NUM_PHASES-1] = '{6'd0, 6'd51, 6'd63, 6'd13, 6'd40};

    localparam logic [7:0] LPS_RANGE [64][4] = '{
        '{8'd128, 8'd176, 8'd208, 8'd240}, '{8'd128, 8'd167, 8'd197, 8'd227},
        '{8'd128, 8'd158, 8'd187, 8'd216}, '{8'd123, 8'd150, 8'd178, 8'd205},
        '{8'd116, 8'd142, 8'd169, 8'd195}, '{8'd111, 8'd135, 8'd160, 8'd185},
        '{8'd105, 8'd128, 8'd152, 8'd175}, '{8'd100, 8'd122, 8'd144, 8'd166},
        '{8'd95,  8'd116, 8'd137, 8'd158}, '{8'd90,  8'd110, 8'd130, 8'd150},
        '{8'd85,  8'd104, 8'd123, 8'd142}, '{8'd81,  8'd99,  8'd117, 8'd135},
        '{8'd77,  8'd94,  8'd111, 8'd128}, '{8'd73,  8'd89,  8'd105, 8'd122},
        '{8'd69,  8'd85,  8'd100, 8'd116}, '{8'd66,  8'd80,  8'd95,  8'd110},
        '{8'd62,  8'd76,  8'd90,  8'd104}, '{8'd59,  8'd72,  8'd86,  8'd99},
        '{8'd56,  8'd69,  8'd81,  8'd94},  '{8'd53,  8'd65,  8'd77,  8'd89},
        '{8'd51,  8'd62,  8'd73,  8'd85},  '{8'd48,  8'd59,  8'd69,  8'd80},
        '{8'd46,  8'd56,  8'd66,  8'd76},  '{8'd43,  8'd53,  8'd63,  8'd72},
        '{8'd41,  8'd50,  8'd59,  8'd69},  '{8'd39,  8'd48,  8'd56,  8'd65},
        '{8'd37,  8'd45,  8'd54,  8'd62},  '{8'd35,  8'd43,  8'd51,  8'd59},
        '{8'd33,  8'd41,  8'd48,  8'd56},  '{8'd32,  8'd39,  8'd46,  8'd53},
        '{8'd30,  8'd37,  8'd43,  8'd50},  '{8'd29,  8'd35,  8'd41,  8'd48},
        '{8'd27,  8'd33,  8'd39,  8'd45},  '{8'd26,  8'd31,  8'd37,  8'd43},
        '{8'd24,  8'd30,  8'd35,  8'd41},  '{8'd23,  8'd28,  8'd33,  8'd39},
        '{8'd22,  8'd27,  8'd32,  8'd37},  '{8'd21,  8'd26,  8'd30,  8'd35},
        '{8'd20,  8'd24,  8'd29,  8'd33},  '{8'd19,  8'd23,  8'd27,  8'd31},
        '{8'd18,  8'd22,  8'd26,  8'd30},  '{8'd17,  8'd21,  8'd25,  8'd28},
        '{8'd16,  8'd20,  8'd23,  8'd27},  '{8'd15,  8'd19,  8'd22,  8'd25},
        '{8'd14,  8'd18,  8'd21,  8'd24},  '{8'd14,  8'd17,  8'd20,  8'd23},
        '{8'd13,  8'd16,  8'd19,  8'd22},  '{8'd12,  8'd15,  8'd18,  8'd21},
        '{8'd12,  8'd14,  8'd17,  8'd20},  '{8'd11,  8'd14,  8'd16,  8'd19},
        '{8'd11,  8'd13,  8'd15,  8'd18},  '{8'd10,  8'd12,  8'd15,  8'd17},
        '{8'd10,  8'd12,  8'd14,  8'd16},  '{8'd9,   8'd11,  8'd13,  8'd15},
        '{8'd9,   8'd11,  8'd12,  8'd14},  '{8'd8,   8'd10,  8'd12,  8'd14},
        '{8'd8,   8'd9,   8'd11,  8'd13},  '{8'd7,   8'd9,   8'd11,  8'd12},
        '{8'd7,   8'd9,   8'd10,  8'd12},  '{8'd7,   8'd8,   8'd10,  8'd11},
        '{8'd6,   8'd8,   8'd9,   8'd11},  '{8'd6,   8'd7,   8'd9,   8'd10},
        '{8'd6,   8'd7,   8'd8,   8'd9},   '{8'd2,   8'd2,   8'd2,   8'd2}
    };

    localparam logic [5:0] NEXT_ON_LPS [64] = '{
        6'd0,  6'd0,  6'd1,  6'd2,  6'd2,  6'd4,  6'd4,  6'd5,
        6'd6,  6'd7,  6'd8,  6'd9,  6'd9,  6'd11, 6'd11, 6'd12,
        6'd13, 6'd13, 6'd15, 6'd15, 6'd16, 6'd16, 6'd18, 6'd18,
        6'd19, 6'd19, 6'd21, 6'd21, 6'd22, 6'd22, 6'd23, 6'd24,
        6'd24, 6'd25, 6'd26, 6'd26, 6'd27, 6'd27, 6'd28, 6'd29,
        6'd29, 6'd30, 6'd30, 6'd30, 6'd31, 6'd32, 6'd32, 6'd33,
        6'd33, 6'd33, 6'd34, 6'd34, 6'd35, 6'd35, 6'd35, 6'd36,
        6'd36, 6'd36, 6'd37, 6'd37, 6'd37, 6'd38, 6'd38, 6'd63
    };

    // renormalization steps after an lps, indexed by rlps[7:3]
    localparam logic [2:0] LPS_RENORM [32] = '{
        3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
    };

    typedef struct {
        logic [2:0]        kind;
        logic [9:0]        idx;
        logic signed [7:0] m;
        logic signed [7:0] n;
        logic [23:0]       bits;
    } bin_req_t;

    typedef struct packed {
        logic       bin;
        logic       used;
        logic [4:0] left;
    } bin_out_t;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic              o_in_stall;
    logic [2:0]        i_req_type      = '0;
    logic [9:0]        i_ctx_index     = '0;
    logic signed [7:0] i_init_m        = '0;
    logic signed [7:0] i_init_n        = '0;
    logic [23:0]       i_stream_bits   = '0;
    logic              o_out_valid;
    logic              i_out_stall     = 1'b0;
    logic              o_bin;
    logic              o_word_consumed;
    logic [4:0]        o_bits_left;
    logic              i_cfg_valid     = 1'b0;
    logic              o_cfg_ready;
    logic [5:0]        i_cfg_data      = '0;

    binary_arithmetic_bin_decoder #(
        .NUM_CONTEXTS (CTX_DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_ctx_index     (i_ctx_index),
        .i_init_m        (i_init_m),
        .i_init_n        (i_init_n),
        .i_stream_bits   (i_stream_bits),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_bin           (o_bin),
        .o_word_consumed (o_word_consumed),
        .o_bits_left     (o_bits_left),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // engine state as the decoder should hold it
    logic [24:0] offset;
    logic [8:0]  rng;
    int          pend;
    logic [6:0]  ctx_mem [CTX_DEPTH];
    logic [5:0]  slice_qp;

    bin_req_t    pending_reqs [$];
    bin_out_t    expected_bins [$];
    bit          ctx_live [CTX_DEPTH];
    int          live_ctx [$];
    int          reqs_made;
    int          reqs_queued;
    int          errors;
    int          results_seen;
    int          idle_cycles;

    bin_req_t    cur_req;
    int          in_wait;
    int          out_wait;
    bit          calm_in;
    bit          calm_out;

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 31) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic void refill_word(input logic [15:0] word, inout bin_out_t e);
        if (pend <= 0) begin
            offset = {offset[8:0], word};
            pend   = pend + 16;
            e.used = 1'b1;
        end
    endfunction

    function automatic void decode_req(input bin_req_t r);
        bin_out_t   e;
        logic [6:0] cx;
        logic [5:0] st;
        logic       mps;
        logic [7:0] rlps;
        logic [2:0] sh;
        logic [8:0] rterm;
        logic [24:0] span;
        int         qp;
        int         m_s;
        int         n_s;
        int         pre;
        e = '0;
        case (r.kind)
            REQ_START: begin
                offset = {1'b0, r.bits};
                rng    = FULL_RANGE;
                pend   = START_PEND;
            end
            REQ_INIT: begin
                qp  = (int'(slice_qp) > QP_CLAMP) ? QP_CLAMP : int'(slice_qp);
                m_s = r.m;
                n_s = r.n;
                pre = ((m_s * qp) >>> 4) + n_s;
                if (pre < 1) begin
                    pre = 1;
                end
                if (pre > 126) begin
                    pre = 126;
                end
                ctx_mem[r.idx] = (pre >= 64) ? {1'b1, 6'(pre - 64)} : {1'b0, 6'(63 - pre)};
            end
            REQ_REGULAR: begin
                cx   = ctx_mem[r.idx];
                st   = cx[5:0];
                mps  = cx[6];
                rlps = LPS_RANGE[st][rng[7:6]];
                rng  = rng - {1'b0, rlps};
                span = {16'b0, rng} << pend;
                if (offset < span) begin
                    e.bin = mps;
                    st    = (st >= 6'd62) ? st : st + 6'd1;
                    if (rng < HALF_RANGE) begin
                        rng  = rng << 1;
                        pend = pend - 1;
                    end
                end else begin
                    sh     = LPS_RENORM[rlps[7:3]];
                    offset = offset - span;
                    rng    = {1'b0, rlps} << sh;
                    pend   = pend - int'(sh);
                    e.bin  = ~mps;
                    // lps in the most uncertain state swaps which symbol is likely
                    if (st == 6'd0) begin
                        mps = ~mps;
                    end
                    st = NEXT_ON_LPS[st];
                end
                ctx_mem[r.idx] = {mps, st};
                refill_word(r.bits[15:0], e);
            end
            REQ_BYPASS: begin
                pend = pend - 1;
                refill_word(r.bits[15:0], e);
                span = {16'b0, rng} << pend;
                if (offset >= span) begin
                    offset = offset - span;
                    e.bin  = 1'b1;
                end
            end
            REQ_TERMINATE: begin
                rterm = rng - TERM_DEC;
                span  = {16'b0, rterm} << pend;
                if (offset < span) begin
                    if (rterm >= HALF_RANGE) begin
                        rng = rterm;
                    end else begin
                        rng  = rterm << 1;
                        pend = pend - 1;
                        refill_word(r.bits[15:0], e);
                    end
                end else begin
                    // end of slice: state stays as it was
                    e.bin = 1'b1;
                end
            end
            default: begin
            end
        endcase
        e.left = 5'(pend);
        expected_bins.push_back(e);
    endfunction

    function automatic void add_req(input logic [2:0] kind, input logic [9:0] idx,
                                    input logic signed [7:0] m, input logic signed [7:0] n,
                                    input logic [23:0] bits);
        bin_req_t r;
        r.kind = kind;
        r.idx  = idx;
        r.m    = m;
        r.n    = n;
        r.bits = bits;
        pending_reqs.push_back(r);
        reqs_made++;
        reqs_queued++;
        if (kind == REQ_INIT && !ctx_live[idx]) begin
            ctx_live[idx] = 1'b1;
            live_ctx.push_back(int'(idx));
        end
    endfunction

    function automatic void add_init();
        logic [9:0]        idx;
        logic signed [7:0] m;
        logic signed [7:0] n;
        idx = 10'($urandom);
        if ($urandom_range(0, 1) == 0) begin
            m = 8'($urandom);
            n = 8'($urandom);
        end else begin
            m = 8'(int'($urandom_range(0, 80)) - 40);
            n = 8'($urandom_range(0, 127));
        end
        add_req(REQ_INIT, idx, m, n, 24'($urandom));
    endfunction

    // one slice: start, a few context inits, then a run of bins with some noise, then a terminate
    task automatic gen_slice();
        int n_init;
        int n_bins;
        int pick;
        add_req(REQ_START, 10'($urandom), 8'($urandom), 8'($urandom), 24'($urandom));
        n_init = (live_ctx.size() < 4) ? 6 : int'($urandom_range(0, 4));
        repeat (n_init) add_init();
        n_bins = $urandom_range(8, 40);
        repeat (n_bins) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                add_req(REQ_REGULAR, 10'(live_ctx[$urandom_range(0, live_ctx.size() - 1)]),
                        8'($urandom), 8'($urandom), 24'($urandom));
            end else if (pick < 82) begin
                add_req(REQ_BYPASS, 10'($urandom), 8'($urandom), 8'($urandom),
                        24'($urandom));
            end else if (pick < 93) begin
                add_req(REQ_TERMINATE, 10'($urandom), 8'($urandom), 8'($urandom),
                        24'($urandom));
            end else if (pick < 96) begin
                add_req(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), 10'($urandom),
                        8'($urandom), 8'($urandom), 24'($urandom));
            end else if (pick < 98) begin
                add_init();
            end else begin
                add_req(REQ_START, 10'($urandom), 8'($urandom), 8'($urandom),
                        24'($urandom));
            end
        end
        add_req(REQ_TERMINATE, 10'($urandom), 8'($urandom), 8'($urandom), 24'($urandom));
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        $display("%0t ns: result %0d %s: got %0d, expected %0d", $time, results_seen,
                 what, got, want);
    endtask

    // idle once every queued transaction has come back as a result
    task automatic wait_idle();
        while (results_seen != reqs_queued) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_qp(input logic [5:0] qp);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= qp;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        slice_qp = qp;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                decode_req(cur_req);
                in_wait = draw_wait(calm_in);
            end
            // a stalled transaction keeps its payload
            if (!(i_in_valid && o_in_stall)) begin
                if (in_wait > 0) begin
                    in_wait--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    cur_req = pending_reqs.pop_front();
                    i_req_type    <= cur_req.kind;
                    i_ctx_index   <= cur_req.idx;
                    i_init_m      <= cur_req.m;
                    i_init_n      <= cur_req.n;
                    i_stream_bits <= cur_req.bits;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        bin_out_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_bins.size() == 0) begin
                    flag_mismatch("arrived with nothing expected", 0, 0);
                end else begin
                    want = expected_bins.pop_front();
                    if (o_bin !== want.bin) begin
                        flag_mismatch("bin", o_bin, want.bin);
                    end
                    if (o_word_consumed !== want.used) begin
                        flag_mismatch("word_consumed", o_word_consumed, want.used);
                    end
                    if (o_bits_left !== want.left) begin
                        flag_mismatch("bits_left", o_bits_left, want.left);
                    end
                end
                out_wait = draw_wait(calm_out);
            end
            if (out_wait > 0) begin
                out_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [5:0] qp;
        offset       = '0;
        rng          = FULL_RANGE;
        pend         = START_PEND;
        slice_qp     = QP_RESET;
        reqs_made    = 0;
        reqs_queued  = 0;
        errors       = 0;
        results_seen = 0;
        idle_cycles  = 0;
        in_wait      = 0;
        out_wait     = 0;
        calm_in      = 1'b0;
        calm_out     = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset state, extremes, clamps, state-zero contexts, end of slice
        add_req(REQ_BYPASS, 10'd0, 8'h00, 8'h00, 24'hFFFFFF);
        add_req(REQ_UNUSED_HI, 10'h3FF, 8'h80, 8'h7F, 24'hFFFFFF);
        add_req(REQ_START, 10'd0, 8'h00, 8'h00, 24'hFFFFFF);
        add_req(REQ_TERMINATE, 10'd0, 8'h00, 8'h00, 24'h000000);
        add_req(REQ_START, 10'd0, 8'h00, 8'h00, 24'h000000);
        add_req(REQ_INIT, 10'd0, 8'h80, 8'h80, 24'h000000);
        add_req(REQ_INIT, 10'h3FF, 8'h7F, 8'h7F, 24'hFFFFFF);
        add_req(REQ_INIT, 10'h200, 8'h00, 8'sd64, 24'h000000);
        add_req(REQ_INIT, 10'h1FF, 8'h00, 8'sd63, 24'h000000);
        // negative slope: the floor shift lands on state zero, truncation would not
        add_req(REQ_INIT, 10'h100, -8'sd1, 8'sd66, 24'h000000);
        add_req(REQ_REGULAR, 10'd0, 8'h00, 8'h00, 24'h000000);
        add_req(REQ_REGULAR, 10'h3FF, 8'h00, 8'h00, 24'h000000);
        add_req(REQ_REGULAR, 10'h200, 8'h00, 8'h00, 24'h000000);
        add_req(REQ_REGULAR, 10'h1FF, 8'h00, 8'h00, 24'h000000);
        add_req(REQ_REGULAR, 10'h100, 8'h7F, 8'h80, 24'hFFFFFF);
        add_req(REQ_BYPASS, 10'h3FF, 8'h00, 8'h00, 24'hFFFFFF);
        add_req(REQ_BYPASS, 10'd0, 8'h00, 8'h00, 24'h000000);
        add_req(REQ_BYPASS, 10'h3FF, 8'h00, 8'h00, 24'hFFFFFF);
        add_req(REQ_TERMINATE, 10'd0, 8'h00, 8'h00, 24'h000000);
        add_req(REQ_REGULAR, 10'h200, 8'h00, 8'h00, 24'hFFFFFF);
        add_req(REQ_UNUSED_LO, 10'd0, 8'h00, 8'h00, 24'h000000);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                wait_idle();
                qp = (ph == NUM_PHASES - 1) ? 6'($urandom_range(0, 63)) : QP_SETTINGS[ph - 1];
                write_qp(qp);
            end
            reqs_made = 0;
            while (reqs_made < PHASE_REQS) begin
                gen_slice();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_bins.size() != 0) begin
            flag_mismatch("left waiting at end", expected_bins.size(), 0);
        end
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### binary_arithmetic_bin_decoder.f
hw/rtl/babd_pkg.sv
hw/rtl/babd_ram.sv
hw/rtl/babd_core.sv
hw/rtl/binary_arithmetic_bin_decoder.sv
test/tb.sv
